@@ hdl/fsg_pkg.sv @@
// Shared types and constants for the falling-sand grid block.
`default_nettype none
package fsg_pkg;

  localparam int unsigned SIDE_DEFAULT = 64;
  localparam logic [15:0] LFSR_MASK    = 16'hB400;

  localparam logic [1:0] KIND_EMPTY = 2'd0;
  localparam logic [1:0] KIND_SAND  = 2'd1;
  localparam logic [1:0] KIND_WATER = 2'd2;
  localparam logic [1:0] KIND_SOLID = 2'd3;

  localparam logic [1:0] REQ_PLACE   = 2'd0;
  localparam logic [1:0] REQ_TICK    = 2'd1;
  localparam logic [1:0] REQ_READ    = 2'd2;
  localparam logic [1:0] REQ_UNKNOWN = 2'd3;

  typedef enum logic [3:0] {
    S_IDLE,
    S_REQ,
    S_T_HERE,
    S_T_CHK,
    S_T_BEL,
    S_T_LEFT,
    S_T_RIGHT,
    S_T_W2,
    S_DONE
  } fsg_state_t;

endpackage
`default_nettype wire

@@ hdl/fsg_grid_mem.sv @@
// Grid cell memory with one read port, one write port and a clearing pass after reset.
`default_nettype none
module fsg_grid_mem import fsg_pkg::*; #(
  parameter int unsigned SIDE = SIDE_DEFAULT
) (
  input  wire                                 clk,
  input  wire                                 rst_n,
  input  wire  [$clog2(SIDE*SIDE)-1:0]        raddr,
  output logic [1:0]                          rdata,
  input  wire                                 we,
  input  wire  [$clog2(SIDE*SIDE)-1:0]        waddr,
  input  wire  [1:0]                          wdata,
  output logic                                busy
);

  localparam int unsigned DEPTH = SIDE * SIDE;
  localparam int unsigned AW    = $clog2(DEPTH);

  logic [1:0]    mem [DEPTH];
  logic          clr_r;
  logic [AW-1:0] clr_addr_r;

  // Sweep every entry to empty after reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r      <= 1'b1;
      clr_addr_r <= '0;
    end else if (clr_r) begin
      clr_addr_r <= clr_addr_r + 1'b1;
      if (clr_addr_r == AW'(DEPTH - 1)) begin
        clr_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (clr_r) begin
      mem[clr_addr_r] <= KIND_EMPTY;
    end else if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

  assign busy = clr_r;

endmodule
`default_nettype wire

@@ hdl/falling_sand_grid_step.sv @@
// Top level of the falling-sand grid block: request sequencer, LFSR and result register.
//
// Usage:
//   Requests enter on in_valid/in_ready with in_req_type, in_col, in_row and in_kind_in.
//   Every request yields one result on out_valid/out_ready (out_cell_value, out_placed).
//   Place and read requests issue the memory read at the accepting edge; the cell is then
//   checked and written in S_REQ, and the result goes from the holding stage into the
//   output register in S_DONE. No new request is taken until the block is back in idle.
//   A tick walks every cell of rows SIDE-2 up to 0. Each cell is read and tested in
//   S_T_HERE and S_T_CHK; a sand or water cell then fetches below, below-left and below-right,
//   one per cycle through the single read port of the grid memory, and writes twice, moving or not.
//   After reset the grid memory is swept to empty, one cell per cycle (all SIDE*SIDE cells,
//   4096 at the default size); in_ready stays low during that sweep.
//   Reset loads the LFSR with 1; a cfg_we write loads cfg_wdata (zero becomes 1).
//   A finished result waits in a holding stage when the receiver stalls, while the output
//   register keeps the earlier one; the next request is taken once the block is back
//   in idle, so one result may wait while the next request is accepted.
`default_nettype none
module falling_sand_grid_step import fsg_pkg::*; #(
  parameter int unsigned SIDE = SIDE_DEFAULT
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_valid,
  output logic        in_ready,
  input  wire  [1:0]  in_req_type,
  input  wire  [5:0]  in_col,
  input  wire  [5:0]  in_row,
  input  wire  [1:0]  in_kind_in,
  output logic        out_valid,
  input  wire         out_ready,
  output logic [1:0]  out_cell_value,
  output logic        out_placed,
  input  wire         cfg_we,
  input  wire  [15:0] cfg_wdata
);

  localparam int unsigned AW = $clog2(SIDE * SIDE);
  localparam int unsigned CW = $clog2(SIDE);

  function automatic logic [AW-1:0] cell_addr(input logic [CW-1:0] r, input logic [CW-1:0] c);
    cell_addr = AW'(r) * AW'(SIDE) + AW'(c);
  endfunction

  fsg_state_t state_r, state_nxt;

  logic [1:0]    req_r;
  logic [1:0]    kind_r;
  logic          inside_r;
  logic [AW-1:0] addr_r;
  logic [CW-1:0] row_r, row_nxt;
  logic [CW-1:0] col_r, col_nxt;
  logic [1:0]    here_r, here_nxt;
  logic [1:0]    below_r, below_nxt;
  logic [1:0]    left_r, left_nxt;
  logic [AW-1:0] tgt_r, tgt_nxt;
  logic [15:0]   lfsr_r;
  logic          lfsr_step;
  logic [1:0]    res_value_r, res_value_nxt;
  logic          res_placed_r, res_placed_nxt;
  logic          out_valid_r;
  logic [1:0]    out_value_r;
  logic          out_placed_r;

  logic [AW-1:0] mem_raddr, mem_waddr;
  logic [1:0]    mem_rdata, mem_wdata;
  logic          mem_we, mem_busy;

  logic          in_fire, inside_in, out_load;
  logic [CW-1:0] col_l, col_rt, row_b;
  logic          left_free, right_free, sinks;
  logic          last_col, advance_done;

  fsg_grid_mem #(.SIDE(SIDE)) u_mem (
    .clk   (clk),
    .rst_n (rst_n),
    .raddr (mem_raddr),
    .rdata (mem_rdata),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .busy  (mem_busy)
  );

  assign in_ready  = (state_r == S_IDLE) && !mem_busy;
  assign in_fire   = in_valid && in_ready;
  assign inside_in = (9'(in_col) < 9'(SIDE)) && (9'(in_row) < 9'(SIDE));

  // Neighbor coordinates, clamped so edge columns never address outside the grid.
  assign row_b      = row_r + 1'b1;
  assign col_l      = (col_r == '0) ? col_r : col_r - 1'b1;
  assign col_rt     = (col_r == CW'(SIDE - 1)) ? col_r : col_r + 1'b1;
  assign last_col   = (col_r == CW'(SIDE - 1));
  assign left_free  = (col_r != '0) && (left_r == KIND_EMPTY);
  assign right_free = !last_col && (mem_rdata == KIND_EMPTY);
  assign sinks      = (here_r == KIND_SAND);
  assign advance_done = last_col && (row_r == '0);

  // Result leaves the holding stage once the output register is free.
  assign out_load = (state_r == S_DONE) && (!out_valid_r || out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      lfsr_r      <= 16'd1;
    end else begin
      state_r <= state_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_we) begin
        lfsr_r <= (cfg_wdata == 16'd0) ? 16'd1 : cfg_wdata;
      end else if (lfsr_step) begin
        lfsr_r <= (lfsr_r >> 1) ^ (lfsr_r[0] ? LFSR_MASK : 16'd0);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      req_r    <= in_req_type;
      kind_r   <= in_kind_in;
      inside_r <= inside_in;
      addr_r   <= cell_addr(CW'(in_row), CW'(in_col));
    end
    row_r        <= row_nxt;
    col_r        <= col_nxt;
    here_r       <= here_nxt;
    below_r      <= below_nxt;
    left_r       <= left_nxt;
    tgt_r        <= tgt_nxt;
    res_value_r  <= res_value_nxt;
    res_placed_r <= res_placed_nxt;
    if (out_load) begin
      out_value_r  <= res_value_r;
      out_placed_r <= res_placed_r;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    row_nxt        = row_r;
    col_nxt        = col_r;
    here_nxt       = here_r;
    below_nxt      = below_r;
    left_nxt       = left_r;
    tgt_nxt        = tgt_r;
    res_value_nxt  = res_value_r;
    res_placed_nxt = res_placed_r;
    mem_raddr      = cell_addr(row_r, col_r);
    mem_we         = 1'b0;
    mem_waddr      = cell_addr(row_r, col_r);
    mem_wdata      = KIND_EMPTY;
    lfsr_step      = 1'b0;

    case (state_r)
      S_IDLE: begin
        mem_raddr = cell_addr(CW'(in_row), CW'(in_col));
        if (in_fire) begin
          res_value_nxt  = KIND_EMPTY;
          res_placed_nxt = 1'b0;
          row_nxt        = CW'(SIDE - 2);
          col_nxt        = '0;
          case (in_req_type)
            REQ_PLACE, REQ_READ: state_nxt = S_REQ;
            REQ_TICK:            state_nxt = S_T_HERE;
            default:             state_nxt = S_DONE;
          endcase
        end
      end
      S_REQ: begin
        // Cell data is back; place into an empty cell, or return it on a read.
        if (req_r == REQ_PLACE) begin
          if (inside_r && kind_r != KIND_EMPTY && mem_rdata == KIND_EMPTY) begin
            mem_we         = 1'b1;
            mem_waddr      = addr_r;
            mem_wdata      = kind_r;
            res_placed_nxt = 1'b1;
          end
        end else if (inside_r) begin
          res_value_nxt = mem_rdata;
        end
        state_nxt = S_DONE;
      end
      S_T_HERE: begin
        state_nxt = S_T_CHK;
      end
      S_T_CHK: begin
        here_nxt  = mem_rdata;
        mem_raddr = cell_addr(row_b, col_r);
        if (mem_rdata == KIND_SAND || mem_rdata == KIND_WATER) begin
          state_nxt = S_T_BEL;
        end else if (advance_done) begin
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_T_HERE;
          if (last_col) begin
            row_nxt = row_r - 1'b1;
            col_nxt = '0;
          end else begin
            col_nxt = col_r + 1'b1;
          end
        end
      end
      S_T_BEL: begin
        below_nxt = mem_rdata;
        mem_raddr = cell_addr(row_b, col_l);
        state_nxt = S_T_LEFT;
      end
      S_T_LEFT: begin
        left_nxt  = mem_rdata;
        mem_raddr = cell_addr(row_b, col_rt);
        state_nxt = S_T_RIGHT;
      end
      S_T_RIGHT: begin
        // Right neighbor is on the read port now; pick the move target.
        state_nxt = S_T_W2;
        if (below_r == KIND_EMPTY || (sinks && below_r == KIND_WATER)) begin
          tgt_nxt   = cell_addr(row_b, col_r);
          mem_wdata = below_r;
        end else if (left_free && right_free) begin
          lfsr_step = 1'b1;
          if (lfsr_r[0]) begin
            tgt_nxt = cell_addr(row_b, col_rt);
          end else begin
            tgt_nxt = cell_addr(row_b, col_l);
          end
          mem_wdata = KIND_EMPTY;
        end else if (left_free) begin
          tgt_nxt   = cell_addr(row_b, col_l);
          mem_wdata = KIND_EMPTY;
        end else if (right_free) begin
          tgt_nxt   = cell_addr(row_b, col_rt);
          mem_wdata = KIND_EMPTY;
        end else begin
          state_nxt = S_T_W2;
          tgt_nxt   = cell_addr(row_r, col_r);
          mem_wdata = here_r;
        end
        // Write the swapped-in kind into the moving cell; the stay case rewrites itself.
        mem_we    = 1'b1;
        mem_waddr = cell_addr(row_r, col_r);
      end
      S_T_W2: begin
        mem_we    = 1'b1;
        mem_waddr = tgt_r;
        mem_wdata = here_r;
        if (advance_done) begin
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_T_HERE;
          if (last_col) begin
            row_nxt = row_r - 1'b1;
            col_nxt = '0;
          end else begin
            col_nxt = col_r + 1'b1;
          end
        end
      end
      S_DONE: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign out_valid      = out_valid_r;
  assign out_cell_value = out_value_r;
  assign out_placed     = out_placed_r;

endmodule
`default_nettype wire

@@ dv/tb_top.sv @@
// Testbench for the falling-sand grid block: directed and random requests against a grid model.
`timescale 1ns / 100ps
`default_nettype none
module tb_top;
  import fsg_pkg::*;

  localparam int GRID_SIDE = 64;
  localparam int IDLE_LIMIT = 200000;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  in_req_type;
  logic [5:0]  in_col;
  logic [5:0]  in_row;
  logic [1:0]  in_kind_in;
  logic        out_valid;
  logic        out_ready;
  logic [1:0]  out_cell_value;
  logic        out_placed;
  logic        cfg_we;
  logic [15:0] cfg_wdata;

  falling_sand_grid_step i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_req_type(in_req_type), .in_col(in_col), .in_row(in_row), .in_kind_in(in_kind_in),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_cell_value(out_cell_value), .out_placed(out_placed),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  typedef struct packed {
    logic [1:0] cell_value;
    logic       placed;
  } cell_result_t;

  // Model state: our own copy of the grid and the side-choice LFSR.
  logic [1:0]   sand_grid [GRID_SIDE*GRID_SIDE];
  logic [15:0]  side_lfsr;
  cell_result_t pending_results [$];
  int           mismatch_count;
  int           idle_cycles;
  bit           timed_out;
  // Burst/gap state of the sender.
  int           burst_left;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Take bit 0 as the side choice, then advance the Galois LFSR one step.
  function automatic logic pick_side();
    logic b;
    b = side_lfsr[0];
    side_lfsr = side_lfsr >> 1;
    if (b) side_lfsr = side_lfsr ^ LFSR_MASK;
    return b;
  endfunction

  function automatic int idx(int r, int c);
    return r * GRID_SIDE + c;
  endfunction

  function automatic void swap_grid(int a, int b);
    logic [1:0] t;
    t = sand_grid[a];
    sand_grid[a] = sand_grid[b];
    sand_grid[b] = t;
  endfunction

  function automatic void settle_particle(int r, int c, bit sinks);
    int  here;
    int  below;
    bit  lf;
    bit  rf;
    here  = idx(r, c);
    below = idx(r + 1, c);
    lf = (c > 0) && (sand_grid[idx(r + 1, c - 1)] == KIND_EMPTY);
    rf = (c + 1 < GRID_SIDE) && (sand_grid[idx(r + 1, c + 1)] == KIND_EMPTY);
    if (sand_grid[below] == KIND_EMPTY) swap_grid(here, below);
    else if (sinks && sand_grid[below] == KIND_WATER) swap_grid(here, below);
    else if (lf && rf) begin
      if (pick_side()) swap_grid(here, idx(r + 1, c + 1));
      else swap_grid(here, idx(r + 1, c - 1));
    end else if (lf) swap_grid(here, idx(r + 1, c - 1));
    else if (rf) swap_grid(here, idx(r + 1, c + 1));
  endfunction

  // Predict one request's result and update the model grid.
  function automatic cell_result_t predict_cell(logic [1:0] rt, logic [5:0] c,
                                                logic [5:0] r, logic [1:0] k);
    cell_result_t res;
    logic [1:0] kind;
    res = '0;
    if (rt == REQ_PLACE) begin
      if (k != KIND_EMPTY && sand_grid[idx(r, c)] == KIND_EMPTY) begin
        sand_grid[idx(r, c)] = k;
        res.placed = 1'b1;
      end
    end else if (rt == REQ_TICK) begin
      for (int rr = GRID_SIDE - 2; rr >= 0; rr--) begin
        for (int cc = 0; cc < GRID_SIDE; cc++) begin
          kind = sand_grid[idx(rr, cc)];
          if (kind == KIND_SAND) settle_particle(rr, cc, 1'b1);
          else if (kind == KIND_WATER) settle_particle(rr, cc, 1'b0);
        end
      end
    end else if (rt == REQ_READ) begin
      res.cell_value = sand_grid[idx(r, c)];
    end
    return res;
  endfunction

  // Send one request, honoring the burst/gap pattern of the sender.
  // Valid stays high across back-to-back requests; drop it only for a gap.
  task automatic send_request(logic [1:0] rt, logic [5:0] c, logic [5:0] r, logic [1:0] k);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    pending_results.push_back(predict_cell(rt, c, r, k));
    in_valid    <= 1'b1;
    in_req_type <= rt;
    in_col      <= c;
    in_row      <= r;
    in_kind_in  <= k;
    do @(posedge clk); while (!(in_valid && in_ready));
  endtask

  // Hold until every expected result is back, then let the block settle.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_results.size() != 0 && !timed_out) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_seed(logic [15:0] seed);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_wdata <= seed;
    @(posedge clk);
    cfg_we <= 1'b0;
    side_lfsr = (seed == 16'd0) ? 16'd1 : seed;
  endtask

  // Receiver: stall on a pattern that changes mode every so often.
  int stall_mode;
  int stall_cnt;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      stall_cnt <= 0;
      stall_mode <= 0;
    end else begin
      stall_cnt <= stall_cnt + 1;
      if (stall_cnt % 64 == 0) stall_mode <= $urandom_range(0, 3);
      case (stall_mode)
        0: out_ready <= 1'b1;
        1: out_ready <= ($urandom_range(0, 3) != 0);
        2: out_ready <= stall_cnt[2];
        default: out_ready <= ($urandom_range(0, 1) != 0);
      endcase
    end
  end

  // Check each accepted result against the oldest expectation.
  always @(posedge clk) begin
    cell_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) $display("unexpected result value=%0d placed=%0d",
                                           out_cell_value, out_placed);
      end else begin
        want = pending_results.pop_front();
        if (want.cell_value !== out_cell_value || want.placed !== out_placed) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("mismatch: expected value=%0d placed=%0d, got value=%0d placed=%0d",
                     want.cell_value, want.placed, out_cell_value, out_placed);
        end
      end
    end
  end

  // Watchdog: count cycles in which nothing is accepted.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAIL falling_sand_grid_step");
      $finish;
    end
  end

  task automatic test_place_and_read();
    send_request(REQ_READ, 6'd0, 6'd0, KIND_SAND);
    send_request(REQ_PLACE, 6'd0, 6'd0, KIND_SAND);
    send_request(REQ_PLACE, 6'd0, 6'd0, KIND_WATER);      // occupied cell
    send_request(REQ_PLACE, 6'd63, 6'd63, KIND_SOLID);
    send_request(REQ_PLACE, 6'd5, 6'd5, KIND_EMPTY);      // kind zero places nothing
    send_request(REQ_PLACE, 6'd63, 6'd0, KIND_WATER);
    send_request(REQ_UNKNOWN, 6'd63, 6'd63, KIND_SOLID);  // unknown request
    send_request(REQ_READ, 6'd0, 6'd0, KIND_EMPTY);
    send_request(REQ_READ, 6'd63, 6'd63, KIND_WATER);
    send_request(REQ_READ, 6'd63, 6'd0, KIND_SOLID);
  endtask

  task automatic test_tick_physics();
    // Sand over water, a pile with both sides free, and the left edge column.
    send_request(REQ_PLACE, 6'd10, 6'd62, KIND_WATER);
    send_request(REQ_PLACE, 6'd10, 6'd61, KIND_SAND);
    send_request(REQ_PLACE, 6'd20, 6'd63, KIND_SOLID);
    send_request(REQ_PLACE, 6'd20, 6'd62, KIND_SAND);
    send_request(REQ_PLACE, 6'd0, 6'd62, KIND_SAND);
    send_request(REQ_PLACE, 6'd62, 6'd63, KIND_SOLID);
    send_request(REQ_TICK, 6'd0, 6'd0, KIND_EMPTY);
    send_request(REQ_TICK, 6'd0, 6'd0, KIND_EMPTY);
    send_request(REQ_READ, 6'd10, 6'd62, KIND_EMPTY);
    send_request(REQ_READ, 6'd10, 6'd63, KIND_EMPTY);
    send_request(REQ_READ, 6'd21, 6'd63, KIND_EMPTY);
    send_request(REQ_READ, 6'd19, 6'd63, KIND_EMPTY);
  endtask

  task automatic test_random_mix(int count);
    int sel;
    for (int i = 0; i < count; i++) begin
      sel = $urandom_range(0, 99);
      // Mostly places near the bottom so ticks have plenty to move.
      if (sel < 55)
        send_request(REQ_PLACE, 6'($urandom), 6'($urandom_range(40, 63)), 2'($urandom));
      else if (sel < 65) send_request(REQ_TICK, 6'($urandom), 6'($urandom), 2'($urandom));
      else if (sel < 95)
        send_request(REQ_READ, 6'($urandom), 6'($urandom), 2'($urandom));
      else send_request(REQ_UNKNOWN, 6'($urandom), 6'($urandom), 2'($urandom));
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_req_type = '0;
    in_col = '0;
    in_row = '0;
    in_kind_in = '0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    mismatch_count = 0;
    timed_out = 1'b0;
    burst_left = 0;
    side_lfsr = 16'd1;
    for (int i = 0; i < GRID_SIDE*GRID_SIDE; i++) sand_grid[i] = KIND_EMPTY;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    test_place_and_read();
    test_tick_physics();
    write_seed(16'hFFFF);
    test_random_mix(30);
    write_seed(16'd0);                       // zero seed loads as one
    test_random_mix(30);
    write_seed(16'($urandom_range(1, 65535)));
    test_random_mix(40);

    wait_drained();
    if (mismatch_count == 0 && pending_results.size() == 0)
      $display("PASS falling_sand_grid_step");
    else
      $display("FAIL falling_sand_grid_step");
    $finish;
  end
endmodule
`default_nettype wire

@@ falling_sand_grid_step.f @@
hdl/fsg_pkg.sv
hdl/fsg_grid_mem.sv
hdl/falling_sand_grid_step.sv
dv/tb_top.sv
